// ===== rtl/ptet_pkg.sv =====
// ----------------------------------------------------------------------------
// ptet_pkg
// Shared types and constants for the periodic timer event table.
// ----------------------------------------------------------------------------
`default_nettype none

package ptet_pkg;

  localparam int unsigned SLOTS   = 16;
  localparam int unsigned TICK_MS = 1;
  localparam int unsigned IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SLOT_W  = 4;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_REG   = 2'd1,
    REQ_UNREG = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    KIND_REG   = 2'd0,
    KIND_UNREG = 2'd1,
    KIND_FIRED = 2'd2
  } kind_e;

  // Classified command between front and back.
  typedef struct packed {
    req_e        req;
    logic [15:0] period;   // already scaled to ticks
    logic [7:0]  tag;
    logic [7:0]  slot_id;
  } cmd_t;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic              ok;
    logic [7:0]        tag;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/ptet_front.sv =====
// ----------------------------------------------------------------------------
// ptet_front
// Accepts request items, drops unused codes, scales the period and queues
// commands (two entries) for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ptet_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [1:0]      req_type_i,
  input  wire logic [15:0]     period_ms_i,
  input  wire logic [7:0]      event_tag_i,
  input  wire logic [7:0]      slot_id_i,
  output logic                 cmd_valid_o,
  output ptet_pkg::cmd_t       cmd_o,
  input  wire logic            cmd_pop_i
);

  ptet_pkg::cmd_t q_mem [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           keep;
  logic           wr_en, rd_en;
  ptet_pkg::cmd_t cmd_in;

  always_comb begin
    keep = 1'b0;
    unique case (req_type_i) inside
      ptet_pkg::REQ_TICK, ptet_pkg::REQ_REG, ptet_pkg::REQ_UNREG: keep = 1'b1;
      default: keep = 1'b0;  // unused code: no result
    endcase
  end

  always_comb begin
    cmd_in.req     = ptet_pkg::req_e'(req_type_i);
    cmd_in.period  = 16'(32'(period_ms_i) / ptet_pkg::TICK_MS);
    cmd_in.tag     = event_tag_i;
    cmd_in.slot_id = slot_id_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign wr_en       = push && !full && keep;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) cnt_d = cnt_q + 2'd1;
    else if (!wr_en && rd_en) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) wr_ptr_q <= !wr_ptr_q;
      if (rd_en) rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) q_mem[wr_ptr_q] <= cmd_in;
  end

endmodule

`default_nettype wire

// ===== rtl/ptet_back.sv =====
// ----------------------------------------------------------------------------
// ptet_back
// Timer table and sequencer: register/unregister in one step; a tick walks
// one slot per cycle unless stalled, holding back one firing to mark the last.
// ----------------------------------------------------------------------------
`default_nettype none

module ptet_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cmd_valid_i,
  input  wire ptet_pkg::cmd_t      cmd_i,
  output logic                     cmd_pop_o,
  output logic                     res_push_o,
  output ptet_pkg::res_t           res_o,
  input  wire logic                res_full_i
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_e;

  localparam logic [ptet_pkg::IDX_W-1:0] LAST_IDX =
    ptet_pkg::IDX_W'(ptet_pkg::SLOTS - 1);

  state_e                       state_q, state_d;
  logic [ptet_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic                         held_v_q, held_v_d;
  ptet_pkg::res_t               held_q, held_d;

  logic [ptet_pkg::SLOTS-1:0]   used_q;
  logic [15:0]                  cnt_q    [ptet_pkg::SLOTS];
  logic [15:0]                  reload_q [ptet_pkg::SLOTS];
  logic [7:0]                   tag_q    [ptet_pkg::SLOTS];

  logic [ptet_pkg::IDX_W-1:0]   free_idx;
  logic                         found;
  logic                         in_range;
  logic                         do_cmd, do_reg, do_unreg, do_tick;
  logic [15:0]                  cur_cnt, dec_cnt;
  logic                         fire, stall, step;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    found    = 1'b0;
    for (int i = ptet_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = ptet_pkg::IDX_W'(i);
        found    = 1'b1;
      end
    end
  end

  assign in_range = (int'(cmd_i.slot_id) < int'(ptet_pkg::SLOTS));

  assign do_cmd   = (state_q == S_IDLE) && cmd_valid_i &&
                    ((cmd_i.req == ptet_pkg::REQ_TICK) || !res_full_i);
  assign do_reg   = do_cmd && (cmd_i.req == ptet_pkg::REQ_REG);
  assign do_unreg = do_cmd && (cmd_i.req == ptet_pkg::REQ_UNREG);
  assign do_tick  = do_cmd && (cmd_i.req == ptet_pkg::REQ_TICK);
  assign cmd_pop_o = do_cmd;

  assign cur_cnt = cnt_q[idx_q];
  assign dec_cnt = cur_cnt - 16'd1;
  assign fire    = (cur_cnt != 16'd0) && (dec_cnt == 16'd0) && used_q[idx_q];
  // a new firing pushes out the held one; wait for room
  assign stall   = fire && held_v_q && res_full_i;
  assign step    = (state_q == S_WALK) && !stall;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    held_v_d   = held_v_q;
    held_d     = held_q;
    res_push_o = 1'b0;
    res_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (do_reg) begin
          res_push_o = 1'b1;
          res_o.kind = ptet_pkg::KIND_REG;
          res_o.slot = found ? ptet_pkg::SLOT_W'(free_idx) : '0;
          res_o.ok   = found;
          res_o.last = 1'b1;
        end else if (do_unreg) begin
          res_push_o = 1'b1;
          res_o.kind = ptet_pkg::KIND_UNREG;
          res_o.slot = in_range ? ptet_pkg::SLOT_W'(cmd_i.slot_id) : '0;
          res_o.ok   = in_range;
          res_o.last = 1'b1;
        end else if (do_tick) begin
          state_d  = S_WALK;
          idx_d    = '0;
          held_v_d = 1'b0;
        end
      end
      S_WALK: begin
        if (step) begin
          if (fire) begin
            res_push_o  = held_v_q;
            res_o       = held_q;
            held_v_d    = 1'b1;
            held_d.kind = ptet_pkg::KIND_FIRED;
            held_d.slot = ptet_pkg::SLOT_W'(idx_q);
            held_d.ok   = 1'b1;
            held_d.tag  = tag_q[idx_q];
            held_d.last = 1'b0;
          end
          if (idx_q == LAST_IDX) state_d = S_DONE;
          else idx_d = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!held_v_q) begin
          state_d = S_IDLE;
        end else if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o      = held_q;
          res_o.last = 1'b1;
          held_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      held_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      held_v_q <= held_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  // timer table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      for (int i = 0; i < ptet_pkg::SLOTS; i++) begin
        cnt_q[i]    <= '0;
        reload_q[i] <= '0;
        tag_q[i]    <= '0;
      end
    end else begin
      if (do_reg && found) begin
        used_q[free_idx]   <= 1'b1;
        reload_q[free_idx] <= cmd_i.period;
        cnt_q[free_idx]    <= cmd_i.period;
        tag_q[free_idx]    <= cmd_i.tag;
      end
      if (do_unreg && in_range) begin
        used_q[ptet_pkg::IDX_W'(cmd_i.slot_id)] <= 1'b0;
        cnt_q[ptet_pkg::IDX_W'(cmd_i.slot_id)]  <= '0;
      end
      if (step && (cur_cnt != 16'd0)) begin
        cnt_q[idx_q] <= fire ? reload_q[idx_q] : dec_cnt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ptet_res_q.sv =====
// ----------------------------------------------------------------------------
// ptet_res_q
// Two-entry result queue toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module ptet_res_q (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire ptet_pkg::res_t data_i,
  output logic            full_o,
  output logic            empty,
  input  wire logic       pop,
  output ptet_pkg::res_t  data_o
);

  ptet_pkg::res_t q_mem [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           wr_en, rd_en;

  assign full_o = (cnt_q == 2'd2);
  assign empty  = (cnt_q == 2'd0);
  assign data_o = q_mem[rd_ptr_q];
  assign wr_en  = push_i && !full_o;
  assign rd_en  = pop && !empty;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) cnt_d = cnt_q + 2'd1;
    else if (!wr_en && rd_en) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) wr_ptr_q <= !wr_ptr_q;
      if (rd_en) rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) q_mem[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

// ===== rtl/periodic_timer_event_table.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_event_table
// Table of periodic timers: register, unregister and tick requests in,
// register/unregister replies and fired events out, both as queues.
// ----------------------------------------------------------------------------
// A register or unregister reply is registered in the front queue, then in
//   the result queue, before it can be popped. The back end takes each such
//   command and pushes its reply in the same cycle; a tick runs a dispatch
//   step, a step per slot, a closing step, plus stalls on a full result queue.
// Reset: async, active low; clears the table (all slots free, counts zero)
//   and both queues at once, no clearing pass.
`default_nettype none

module periodic_timer_event_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request side
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [15:0] period_ms_i,
  input  wire logic [7:0]  event_tag_i,
  input  wire logic [7:0]  slot_id_i,
  // result side
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       reply_kind_o,
  output logic [3:0]       slot_o,
  output logic             ok_o,
  output logic [7:0]       fired_tag_o,
  output logic             last_o
);

  // front -> back command channel
  logic           cmd_valid;
  logic           cmd_pop;
  ptet_pkg::cmd_t cmd;

  // back -> result queue
  logic           res_push;
  logic           res_full;
  ptet_pkg::res_t res_in;
  ptet_pkg::res_t res_out;

  // Front end: takes items, drops the unused request code, converts the
  // period to ticks and buffers up to two commands.
  ptet_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_type_i  (req_type_i),
    .period_ms_i (period_ms_i),
    .event_tag_i (event_tag_i),
    .slot_id_i   (slot_id_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: owns the table. A tick keeps one fired item in hand so the
  // last one of the walk can carry the last flag.
  ptet_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  // Result queue decouples the consumer from the walk.
  ptet_res_q u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .empty  (empty),
    .pop    (pop),
    .data_o (res_out)
  );

  assign reply_kind_o = res_out.kind;
  assign slot_o       = res_out.slot;
  assign ok_o         = res_out.ok;
  assign fired_tag_o  = res_out.tag;
  assign last_o       = res_out.last;

  // The back end never pushes into a full result queue.
  a_no_res_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // Commands are only taken when one is queued.
  a_cmd_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // Fired events always report success.
  a_fired_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_out.kind == ptet_pkg::KIND_FIRED) |-> ok_o)
    else $error("fired event without ok");

  // Replies to register/unregister are single items and always last.
  a_reply_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (res_out.kind == ptet_pkg::KIND_REG ||
                res_out.kind == ptet_pkg::KIND_UNREG)) |-> last_o)
    else $error("reply not marked last");

endmodule

`default_nettype wire

// ===== tb/periodic_timer_event_table_tb.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_event_table_tb
// Self-checking bench for the periodic timer table. Register, unregister,
// tick and unused requests go in through the push/full queue port. Replies
// and fired events come out through the empty/pop port. A scoreboard keeps
// its own copy of the slot table and predicts every reply and firing.
// Both sides idle at random, and the result side holds off for a long
// stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_event_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // req_type encoding that the block drops without a reply
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // firings reported per tick at most
  localparam int unsigned MAX_FIRED = 16;
  // random items after the directed part
  localparam int unsigned RANDOM_ITEMS = 300;
  // long hold-off on the result side, in cycles
  localparam int unsigned HOLD_CYCLES = 400;
  // drain time: twice a tick walk (dispatch, a step per slot, closing step) plus pipe slack
  localparam int unsigned DRAIN_CYCLES = 2 * (ptet_pkg::SLOTS + 2) + 8;

  // --------------------------------------------------------------------------
  // Scoreboard: private copy of the slot table plus the queue of results
  // that the accepted requests still owe.
  // --------------------------------------------------------------------------
  class timer_table_scoreboard;
    bit        used    [ptet_pkg::SLOTS];
    bit [15:0] reload  [ptet_pkg::SLOTS];
    bit [15:0] count   [ptet_pkg::SLOTS];
    bit [7:0]  tag_of  [ptet_pkg::SLOTS];
    ptet_pkg::res_t owed_results [$];
    int unsigned errors;

    function void note_request(logic [1:0] req, logic [15:0] period_ms,
                               logic [7:0] tag, logic [7:0] sid);
      ptet_pkg::res_t r;
      ptet_pkg::res_t held;
      bit   have_held;
      int   fired;
      int   idx;
      have_held = 1'b0;
      fired     = 0;
      idx       = -1;
      case (req)
        ptet_pkg::REQ_TICK: begin
          // walk slots low to high; each firing is held back one step so
          // the last one can be marked
          for (int i = 0; i < ptet_pkg::SLOTS; i++) begin
            if (count[i] != 16'd0) begin
              count[i] = count[i] - 16'd1;
              if (count[i] == 16'd0 && used[i]) begin
                count[i] = reload[i];
                if (fired < MAX_FIRED) begin
                  if (have_held) owed_results.push_back(held);
                  held.kind = ptet_pkg::KIND_FIRED;
                  held.slot = ptet_pkg::SLOT_W'(i);
                  held.ok   = 1'b1;
                  held.tag  = tag_of[i];
                  held.last = 1'b0;
                  have_held = 1'b1;
                  fired++;
                end
              end
            end
          end
          if (have_held) begin
            held.last = 1'b1;
            owed_results.push_back(held);
          end
        end
        ptet_pkg::REQ_REG: begin
          for (int i = ptet_pkg::SLOTS - 1; i >= 0; i--)
            if (!used[i]) idx = i;
          r.kind = ptet_pkg::KIND_REG;
          r.tag  = 8'd0;
          r.last = 1'b1;
          if (idx < 0) begin
            // table full: nothing changes
            r.slot = '0;
            r.ok   = 1'b0;
          end else begin
            used[idx]   = 1'b1;
            reload[idx] = 16'(period_ms / ptet_pkg::TICK_MS);
            count[idx]  = reload[idx];
            tag_of[idx] = tag;
            r.slot = ptet_pkg::SLOT_W'(idx);
            r.ok   = 1'b1;
          end
          owed_results.push_back(r);
        end
        ptet_pkg::REQ_UNREG: begin
          r.kind = ptet_pkg::KIND_UNREG;
          r.tag  = 8'd0;
          r.last = 1'b1;
          if (sid < ptet_pkg::SLOTS) begin
            used[sid]  = 1'b0;
            count[sid] = 16'd0;
            r.slot = ptet_pkg::SLOT_W'(sid);
            r.ok   = 1'b1;
          end else begin
            r.slot = '0;
            r.ok   = 1'b0;
          end
          owed_results.push_back(r);
        end
        default: ;  // unused encoding, dropped
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [3:0] slot, logic ok,
                               logic [7:0] tag, logic last);
      ptet_pkg::res_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0h slot %0h tag %0h",
                 $time, kind, slot, tag);
        errors++;
      end else begin
        want = owed_results.pop_front();
        compare_field("reply_kind", 8'(want.kind), 8'(kind));
        compare_field("slot",       8'(want.slot), 8'(slot));
        compare_field("ok",         8'(want.ok),   8'(ok));
        compare_field("fired_tag",  want.tag,      tag);
        compare_field("last",       8'(want.last), 8'(last));
      end
    endfunction

    function void close_out();
      if (owed_results.size() != 0) begin
        $display("%0t: results missing, expected %0d more, actual 0",
                 $time, owed_results.size());
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n      = 1'b0;
  logic        push       = 1'b0;
  logic        full;
  logic [1:0]  req_type   = '0;
  logic [15:0] period_ms  = '0;
  logic [7:0]  event_tag  = '0;
  logic [7:0]  slot_id    = '0;
  logic        empty;
  logic        pop        = 1'b0;
  logic [1:0]  reply_kind;
  logic [3:0]  slot;
  logic        ok;
  logic [7:0]  fired_tag;
  logic        last;

  periodic_timer_event_table u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push         (push),
    .full         (full),
    .req_type_i   (req_type),
    .period_ms_i  (period_ms),
    .event_tag_i  (event_tag),
    .slot_id_i    (slot_id),
    .empty        (empty),
    .pop          (pop),
    .reply_kind_o (reply_kind),
    .slot_o       (slot),
    .ok_o         (ok),
    .fired_tag_o  (fired_tag),
    .last_o       (last)
  );

  timer_table_scoreboard sb;

  // stimulus-side controls
  bit          back_to_back   = 1'b0;   // sender skips its gaps
  bit          hold_off_req   = 1'b0;   // ask the receiver for a long stall
  int unsigned counted_items  = 0;      // items that the block acts on

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog, sized from a worst case of 16 results per item, each waiting
  // out the longest receiver stall, taken a few times over.
  initial begin
    #40ms;
    $display("[periodic_timer_event_table] ERROR");
    $finish;
  end

  // Gap length: mostly none, often short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Mostly short periods so slots fire often; zero and full-range now and then.
  function automatic logic [15:0] short_period();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return 16'($urandom_range(1, 6) * ptet_pkg::TICK_MS);
    if (r == 8) return 16'd0;
    return 16'($urandom());
  endfunction

  // --------------------------------------------------------------------------
  // Request side. push stays high across back-to-back items; it only drops
  // when a gap is inserted.
  // --------------------------------------------------------------------------
  task automatic offer_request(input logic [1:0] req, input logic [15:0] ms,
                               input logic [7:0] tag, input logic [7:0] sid);
    int gap;
    gap = back_to_back ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    req_type  <= req;
    period_ms <= ms;
    event_tag <= tag;
    slot_id   <= sid;
    @(posedge clk);
    while (full) @(posedge clk);
    // accepted at this edge
    sb.note_request(req, ms, tag, sid);
    if (req != REQ_UNUSED) counted_items++;
  endtask

  // Unused fields carry random noise too so every input bit toggles.
  task automatic offer_tick();
    offer_request(ptet_pkg::REQ_TICK, 16'($urandom()), 8'($urandom()), 8'($urandom()));
  endtask

  task automatic offer_register(input logic [15:0] ms, input logic [7:0] tag);
    offer_request(ptet_pkg::REQ_REG, ms, tag, 8'($urandom()));
  endtask

  task automatic offer_unregister(input logic [7:0] sid);
    offer_request(ptet_pkg::REQ_UNREG, 16'($urandom()), 8'($urandom()), sid);
  endtask

  // Free every slot, refill all of them with period 1 or 2, then tick:
  // up to a full table of firings per tick.
  task automatic mass_firing();
    for (int i = 0; i < ptet_pkg::SLOTS; i++) offer_unregister(8'(i));
    for (int i = 0; i < ptet_pkg::SLOTS; i++)
      offer_register(16'($urandom_range(1, 2) * ptet_pkg::TICK_MS), 8'($urandom()));
    repeat (3) offer_tick();
  endtask

  // --------------------------------------------------------------------------
  // Result side: random pop pattern, plus a long hold-off when asked.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      stall = pick_gap();
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Every popped result goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      sb.check_result(reply_kind, slot, ok, fired_tag, last);
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int pick;
    int unsigned random_start;
    bit held_once;
    bit held_twice;
    sb = new();
    held_once  = 1'b0;
    held_twice = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    offer_tick();                               // empty table: no result
    offer_request(REQ_UNUSED, 16'hFFFF, 8'hFF, 8'hFF);  // dropped silently
    offer_register(16'd0, 8'hFF);               // slot 0, period zero, never fires
    offer_register(16'(ptet_pkg::TICK_MS), 8'hA5);      // slot 1, fires every tick
    offer_register(16'hFFFF, 8'h00);            // slot 2, longest period
    offer_register(16'(3 * ptet_pkg::TICK_MS), 8'h5A);  // slot 3
    offer_tick();
    offer_tick();
    offer_tick();                               // slots 1 and 3 together
    offer_unregister(8'hFF);                    // out of range
    offer_unregister(8'(ptet_pkg::SLOTS));      // first index out of range
    offer_unregister(8'(ptet_pkg::SLOTS - 1));  // in range, never used
    offer_unregister(8'd1);
    // refill from slot 1 up until the table is full
    for (int i = 0; i < ptet_pkg::SLOTS - 3; i++)
      offer_register(16'(ptet_pkg::TICK_MS), 8'($urandom()));
    offer_register(16'(ptet_pkg::TICK_MS), 8'h3C);      // table full
    offer_tick();                               // many firings in one walk
    offer_unregister(8'd0);

    // ---- random part ----
    random_start = counted_items;
    while (counted_items - random_start < RANDOM_ITEMS) begin
      // Long result-side hold-off while requests keep coming back to back,
      // so the result queue fills and the input stalls.
      if ((!held_once && counted_items - random_start > 80) ||
          (!held_twice && counted_items - random_start > 220)) begin
        if (held_once) held_twice = 1'b1;
        held_once    = 1'b1;
        hold_off_req = 1'b1;
        back_to_back = 1'b1;
        mass_firing();
        back_to_back = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // typical traffic: some allocations and frees, then ticks
          repeat ($urandom_range(0, 3)) offer_register(short_period(), 8'($urandom()));
          repeat ($urandom_range(0, 2))
            offer_unregister(8'($urandom_range(0, ptet_pkg::SLOTS - 1)));
          repeat ($urandom_range(1, 6)) offer_tick();
        end else if (pick < 78) begin
          mass_firing();
        end else begin
          // noise: any encoding, any field value
          offer_request(2'($urandom_range(0, 3)), 16'($urandom()),
                        8'($urandom()), 8'($urandom()));
        end
      end
    end

    push <= 1'b0;

    // wait for every owed result, then let a tick walk with no firings finish
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();

    if (sb.errors == 0)
      $display("[periodic_timer_event_table] OK");
    else
      $display("[periodic_timer_event_table] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
